FILE: rtl/hn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Header normalizer package
// Shared types and constants for the header normalizer controller and
// datapath.
// ---------------------------------------------------------------------------
package hn_pkg;

    localparam int BLOB_LEN      = 128;
    localparam int UDP_HDR_LEN   = 8;
    localparam int HELD_BYTES    = 10;

    localparam logic [5:0] ETH_TYPE_POS  = 6'd12;
    localparam logic [5:0] VLAN_TYPE_POS = 6'd2;
    localparam logic [5:0] IP_PROTO_POS  = 6'd9;
    localparam logic [5:0] TCP_OFFS_POS  = 6'd12;
    localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

    localparam logic [15:0] VLAN_TPID    = 16'h8100;
    localparam logic [15:0] L3_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_IPV4  = 2'd1;
    localparam logic [1:0] ST_NOT_L4    = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    typedef enum logic [1:0] {
        SEL_HELD = 2'd0,
        SEL_BYTE = 2'd1,
        SEL_FILL = 2'd2,
        SEL_STAT = 2'd3
    } emit_sel_t;

    typedef struct packed {
        logic held;
        logic byte_en;
        logic fill_en;
        logic stat_en;
    } plan_t;

    typedef struct packed {
        logic      accept;
        logic      emit;
        emit_sel_t sel;
        logic      last;
    } hn_cmd_t;

    typedef struct packed {
        plan_t new_plan;
        plan_t cur_plan;
        logic  held_done;
        logic  fill_done;
        logic  out_free;
    } hn_sts_t;

endpackage
`default_nettype wire

FILE: rtl/hn_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Header normalizer controller
// Accepts one input transaction at a time and sequences the result items
// that it causes: held header bytes, the current byte, fill, then status.
// ---------------------------------------------------------------------------
module hn_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire hn_pkg::hn_sts_t sts,
    output hn_pkg::hn_cmd_t     cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_HELD = 5'b00010,
        S_BYTE = 5'b00100,
        S_FILL = 5'b01000,
        S_STAT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t after_state;

    function automatic state_t pick(hn_pkg::plan_t p);
        state_t s;
        if (p.held)
            s = S_HELD;
        else if (p.byte_en)
            s = S_BYTE;
        else if (p.fill_en)
            s = S_FILL;
        else if (p.stat_en)
            s = S_STAT;
        else
            s = S_IDLE;
        return s;
    endfunction

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.sel     = hn_pkg::SEL_HELD;
        after_state = S_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = pick(sts.new_plan);
                end
            end
            S_HELD:
            begin
                after_state = pick('{held: 1'b0, byte_en: sts.cur_plan.byte_en,
                                     fill_en: sts.cur_plan.fill_en,
                                     stat_en: sts.cur_plan.stat_en});
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = hn_pkg::SEL_HELD;
                    if (sts.held_done)
                    begin
                        cmd.last   = (after_state == S_IDLE);
                        state_next = after_state;
                    end
                end
            end
            S_BYTE:
            begin
                after_state = pick('{held: 1'b0, byte_en: 1'b0,
                                     fill_en: sts.cur_plan.fill_en,
                                     stat_en: sts.cur_plan.stat_en});
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = hn_pkg::SEL_BYTE;
                    cmd.last   = (after_state == S_IDLE);
                    state_next = after_state;
                end
            end
            S_FILL:
            begin
                after_state = pick('{held: 1'b0, byte_en: 1'b0, fill_en: 1'b0,
                                     stat_en: sts.cur_plan.stat_en});
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = hn_pkg::SEL_FILL;
                    if (sts.fill_done)
                    begin
                        cmd.last   = (after_state == S_IDLE);
                        state_next = after_state;
                    end
                end
            end
            S_STAT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = hn_pkg::SEL_STAT;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

FILE: rtl/hn_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Header normalizer datapath
// Parse state, held IPv4 header bytes, emission plan and counters, and the
// output register.
// ---------------------------------------------------------------------------
module hn_datapath #(
    parameter int HEADER_SLOT = 60
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  in_byte,
    input  wire logic        frame_last,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    input  wire hn_pkg::hn_cmd_t cmd,
    output hn_pkg::hn_sts_t  sts,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic [6:0]       blob_index,
    output logic             is_status,
    output logic [1:0]       status,
    output logic             last
);

    localparam logic [6:0] IP_SLOT  = 7'(HEADER_SLOT);
    localparam logic [6:0] TCP_TAIL = 7'(hn_pkg::BLOB_LEN - HEADER_SLOT);
    localparam logic [6:0] UDP_TAIL = 7'(hn_pkg::BLOB_LEN - HEADER_SLOT - hn_pkg::UDP_HDR_LEN);
    localparam logic [3:0] HELD_LAST = 4'(hn_pkg::HELD_BYTES - 1);

    typedef enum logic [5:0] {
        PH_ETH  = 6'b000001,
        PH_VLAN = 6'b000010,
        PH_IP   = 6'b000100,
        PH_L4   = 6'b001000,
        PH_DONE = 6'b010000,
        PH_ERR  = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [5:0]  pos_reg, pos_next;
    logic [7:0]  etype_hi_reg, etype_hi_next;
    logic [5:0]  ihl_reg, ihl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [5:0]  l4len_reg, l4len_next;
    logic [1:0]  fstat_reg, fstat_next;
    logic [7:0]  fill_byte_reg;

    logic [7:0]  held_mem [hn_pkg::HELD_BYTES];
    logic        store_we;

    hn_pkg::plan_t new_plan;
    hn_pkg::plan_t plan_reg;
    logic [6:0]  fill_new;
    logic [1:0]  stat_new;
    logic [6:0]  fill_cnt_reg;
    logic [1:0]  stat_reg;
    logic [7:0]  byte_reg;
    logic [3:0]  held_idx_reg;
    logic [6:0]  blob_pos_reg;

    logic [5:0]  type_pos;
    logic [15:0] etype_full;
    logic [5:0]  tcp_len;
    logic [5:0]  l4len_eff;
    logic        brk;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [6:0]  blob_index_reg;
    logic        is_status_reg;
    logic [1:0]  status_reg;
    logic        last_reg;
    logic        out_free;
    logic [7:0]  emit_byte;

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg + 6'd1;
        etype_hi_next = etype_hi_reg;
        ihl_next      = ihl_reg;
        proto_next    = proto_reg;
        l4len_next    = l4len_reg;
        fstat_next    = fstat_reg;
        store_we      = 1'b0;
        new_plan      = '0;
        fill_new      = '0;
        stat_new      = hn_pkg::ST_OK;
        brk           = 1'b0;
        type_pos      = (phase_reg == PH_ETH) ? hn_pkg::ETH_TYPE_POS : hn_pkg::VLAN_TYPE_POS;
        etype_full    = {etype_hi_reg, in_byte};
        tcp_len       = {in_byte[7:4], 2'b00};
        l4len_eff     = l4len_reg;
        case (phase_reg)
            PH_ETH, PH_VLAN:
            begin
                if (pos_reg == type_pos)
                begin
                    etype_hi_next = in_byte;
                end
                else if (pos_reg == type_pos + 6'd1)
                begin
                    if (phase_reg == PH_ETH && etype_full == hn_pkg::VLAN_TPID)
                    begin
                        phase_next = PH_VLAN;
                        pos_next   = '0;
                    end
                    else if (etype_full == hn_pkg::L3_TYPE_IPV4)
                    begin
                        phase_next = PH_IP;
                        pos_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                        fstat_next = hn_pkg::ST_NOT_IPV4;
                    end
                end
            end
            PH_IP:
            begin
                store_we = (pos_reg <= 6'(HELD_LAST));
                if (pos_reg == '0)
                begin
                    ihl_next = {in_byte[3:0], 2'b00};
                    if (in_byte[3:0] < hn_pkg::MIN_HDR_WORDS)
                    begin
                        phase_next = PH_ERR;
                        fstat_next = hn_pkg::ST_MALFORMED;
                        brk        = 1'b1;
                    end
                end
                else if (pos_reg == hn_pkg::IP_PROTO_POS)
                begin
                    proto_next = in_byte;
                    if (in_byte != hn_pkg::PROTO_TCP && in_byte != hn_pkg::PROTO_UDP)
                    begin
                        phase_next = PH_ERR;
                        fstat_next = hn_pkg::ST_NOT_L4;
                        brk        = 1'b1;
                    end
                    else
                    begin
                        new_plan.held = 1'b1;
                    end
                end
                else if (pos_reg > hn_pkg::IP_PROTO_POS)
                begin
                    new_plan.byte_en = 1'b1;
                end
                if (!brk && pos_reg >= hn_pkg::IP_PROTO_POS && pos_reg + 6'd1 == ihl_reg)
                begin
                    fill_new         = IP_SLOT - {1'b0, ihl_reg};
                    new_plan.fill_en = (fill_new != '0);
                    l4len_next       = (proto_reg == hn_pkg::PROTO_UDP) ?
                                       6'(hn_pkg::UDP_HDR_LEN) : 6'd0;
                    phase_next       = PH_L4;
                    pos_next         = '0;
                end
            end
            PH_L4:
            begin
                if (proto_reg == hn_pkg::PROTO_TCP && pos_reg == hn_pkg::TCP_OFFS_POS)
                begin
                    if (in_byte[7:4] < hn_pkg::MIN_HDR_WORDS)
                    begin
                        phase_next = PH_ERR;
                        fstat_next = hn_pkg::ST_MALFORMED;
                        brk        = 1'b1;
                    end
                    else
                    begin
                        l4len_next = tcp_len;
                        l4len_eff  = tcp_len;
                    end
                end
                if (!brk)
                begin
                    new_plan.byte_en = 1'b1;
                    if (l4len_eff != '0 && pos_reg + 6'd1 == l4len_eff)
                    begin
                        fill_new = (proto_reg == hn_pkg::PROTO_TCP) ?
                                   TCP_TAIL - {1'b0, l4len_eff} : UDP_TAIL;
                        new_plan.fill_en = (fill_new != '0);
                        phase_next       = PH_DONE;
                        pos_next         = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (frame_last)
        begin
            new_plan.stat_en = 1'b1;
            if (phase_next == PH_ERR)
                stat_new = fstat_next;
            else if (phase_next == PH_DONE)
                stat_new = hn_pkg::ST_OK;
            else
                stat_new = hn_pkg::ST_MALFORMED;
            phase_next    = PH_ETH;
            pos_next      = '0;
            etype_hi_next = '0;
            ihl_next      = '0;
            proto_next    = '0;
            l4len_next    = '0;
            fstat_next    = hn_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ETH;
            pos_reg       <= '0;
            etype_hi_reg  <= '0;
            ihl_reg       <= '0;
            proto_reg     <= '0;
            l4len_reg     <= '0;
            fstat_reg     <= hn_pkg::ST_OK;
            fill_byte_reg <= '0;
            plan_reg      <= '0;
            held_idx_reg  <= '0;
            fill_cnt_reg  <= '0;
            blob_pos_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                fill_byte_reg <= cfg_wdata;
            if (cmd.accept)
            begin
                phase_reg    <= phase_next;
                pos_reg      <= pos_next;
                etype_hi_reg <= etype_hi_next;
                ihl_reg      <= ihl_next;
                proto_reg    <= proto_next;
                l4len_reg    <= l4len_next;
                fstat_reg    <= fstat_next;
                plan_reg     <= new_plan;
                held_idx_reg <= '0;
                fill_cnt_reg <= fill_new;
            end
            if (cmd.emit)
            begin
                case (cmd.sel)
                    hn_pkg::SEL_HELD: held_idx_reg <= held_idx_reg + 4'd1;
                    hn_pkg::SEL_FILL: fill_cnt_reg <= fill_cnt_reg - 7'd1;
                    default:
                    begin
                    end
                endcase
                if (cmd.sel == hn_pkg::SEL_STAT)
                    blob_pos_reg <= '0;
                else
                    blob_pos_reg <= blob_pos_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= in_byte;
            stat_reg <= stat_new;
            if (store_we)
                held_mem[pos_reg[3:0]] <= in_byte;
        end
    end

    always_comb
    begin
        case (cmd.sel)
            hn_pkg::SEL_HELD: emit_byte = held_mem[held_idx_reg];
            hn_pkg::SEL_BYTE: emit_byte = byte_reg;
            hn_pkg::SEL_FILL: emit_byte = fill_byte_reg;
            default:          emit_byte = '0;
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_byte_reg   <= emit_byte;
            blob_index_reg <= (cmd.sel == hn_pkg::SEL_STAT) ? 7'd0 : blob_pos_reg;
            is_status_reg  <= (cmd.sel == hn_pkg::SEL_STAT);
            status_reg     <= (cmd.sel == hn_pkg::SEL_STAT) ? stat_reg : hn_pkg::ST_OK;
            last_reg       <= cmd.last;
        end
    end

    assign sts.new_plan  = new_plan;
    assign sts.cur_plan  = plan_reg;
    assign sts.held_done = (held_idx_reg == HELD_LAST);
    assign sts.fill_done = (fill_cnt_reg == 7'd1);
    assign sts.out_free  = out_free;

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign blob_index = blob_index_reg;
    assign is_status  = is_status_reg;
    assign status     = status_reg;
    assign last       = last_reg;

endmodule
`default_nettype wire

FILE: rtl/l3_l4_header_normalizer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Timing: a result appears at the output in the cycle after its emission;
// emission starts after the input accept, once the output register is free.
// Throughput: the next input byte waits until the N result items (0 to 62) of
// the last are emitted; output takes one item per cycle unless out_ready stalls.
// Reset: rst_n clears the parse state, the fill byte and the output valid.
// ---------------------------------------------------------------------------
// L3/L4 header normalizer core
// Parses an Ethernet frame byte by byte and streams a fixed 128-byte IPv4 plus
// TCP or UDP header blob, cut short on error, then a status item at frame end.
// ---------------------------------------------------------------------------
module l3_l4_header_normalizer_core #(
    parameter int HEADER_SLOT = 60
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        frame_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic [6:0]       blob_index,
    output logic             is_status,
    output logic [1:0]       status,
    output logic             last,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata
);

    hn_pkg::hn_cmd_t cmd;
    hn_pkg::hn_sts_t sts;

    hn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hn_datapath #(
        .HEADER_SLOT (HEADER_SLOT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (in_byte),
        .frame_last (frame_last),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .blob_index (blob_index),
        .is_status  (is_status),
        .status     (status),
        .last       (last)
    );

endmodule
`default_nettype wire

FILE: test/l3_l4_header_normalizer_core_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Header blob checker
// Watches the byte, result and register ports of the header normalizer,
// predicts every blob byte and status item from the accepted frame bytes,
// and compares each accepted result with the oldest prediction.
// ---------------------------------------------------------------------------
module l3_l4_header_normalizer_core_checker
    import hn_pkg::*;
#(
    parameter int HEADER_SLOT = 60
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       frame_last,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic [6:0] blob_index,
    input  logic       is_status,
    input  logic [1:0] status,
    input  logic       last,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    output int         fail_count,
    output int         pending_count
);

    typedef enum logic [2:0] {
        PS_ETH,
        PS_VLAN,
        PS_IPV4,
        PS_L4,
        PS_DONE,
        PS_ERR
    } parse_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic [6:0] index;
        logic       is_stat;
        logic [1:0] code;
        logic       eop;
    } blob_item_t;

    logic [7:0]   fill_value;
    parse_state_t parse_state;
    int           byte_pos;
    logic [15:0]  seen_type;
    int           ip_hlen;
    logic [7:0]   l4_proto;
    int           l4_hlen;
    logic [7:0]   ip_held [HELD_BYTES];
    logic [6:0]   blob_pos;
    logic [1:0]   frame_code;
    int           mismatches;
    blob_item_t   blob_q[$];
    blob_item_t   burst_q[$];
    blob_item_t   got;
    blob_item_t   want;

    task automatic clear_frame();
        byte_pos    = 0;
        parse_state = PS_ETH;
        seen_type   = '0;
        ip_hlen     = 0;
        l4_proto    = '0;
        l4_hlen     = 0;
        blob_pos    = '0;
        frame_code  = ST_OK;
    endtask

    task automatic emit_blob(input logic [7:0] value);
        burst_q.push_back('{data: value, index: blob_pos, is_stat: 1'b0, code: ST_OK,
                            eop: 1'b0});
        blob_pos = blob_pos + 7'd1;
    endtask

    task automatic emit_fill(input int count);
        repeat (count) emit_blob(fill_value);
    endtask

    task automatic abort_frame(input logic [1:0] code);
        parse_state = PS_ERR;
        frame_code  = code;
    endtask

    task automatic predict_frame_byte(input logic [7:0] b, input logic eof);
        int         pos;
        int         type_pos;
        bit         advance;
        logic [1:0] end_code;

        pos     = byte_pos;
        advance = 1'b1;
        burst_q.delete();
        case (parse_state)
            PS_ETH, PS_VLAN:
            begin
                type_pos = (parse_state == PS_ETH) ? ETH_TYPE_POS : VLAN_TYPE_POS;
                if (pos == type_pos) begin
                    seen_type = {b, 8'h00};
                end else if (pos == type_pos + 1) begin
                    seen_type[7:0] = b;
                    if (parse_state == PS_ETH && seen_type == VLAN_TPID) begin
                        parse_state = PS_VLAN;
                        byte_pos    = 0;
                        advance     = 1'b0;
                    end else if (seen_type == L3_TYPE_IPV4) begin
                        parse_state = PS_IPV4;
                        byte_pos    = 0;
                        advance     = 1'b0;
                    end else begin
                        abort_frame(ST_NOT_IPV4);
                    end
                end
            end
            PS_IPV4:
            begin
                if (pos < HELD_BYTES)
                    ip_held[pos] = b;
                if (pos == 0) begin
                    ip_hlen = int'(b[3:0]) * 4;
                    if (b[3:0] < MIN_HDR_WORDS)
                        abort_frame(ST_MALFORMED);
                end else if (pos == IP_PROTO_POS) begin
                    l4_proto = b;
                    if (b != PROTO_TCP && b != PROTO_UDP) begin
                        abort_frame(ST_NOT_L4);
                    end else begin
                        for (int i = 0; i < HELD_BYTES; i++)
                            emit_blob(ip_held[i]);
                    end
                end else if (pos > IP_PROTO_POS) begin
                    emit_blob(b);
                end
                if (parse_state == PS_IPV4 && pos >= IP_PROTO_POS && pos + 1 == ip_hlen) begin
                    emit_fill(HEADER_SLOT - ip_hlen);
                    l4_hlen     = (l4_proto == PROTO_UDP) ? UDP_HDR_LEN : 0;
                    parse_state = PS_L4;
                    byte_pos    = 0;
                    advance     = 1'b0;
                end
            end
            PS_L4:
            begin
                if (l4_proto == PROTO_TCP && pos == TCP_OFFS_POS && b[7:4] < MIN_HDR_WORDS) begin
                    abort_frame(ST_MALFORMED);
                end else begin
                    if (l4_proto == PROTO_TCP && pos == TCP_OFFS_POS)
                        l4_hlen = int'(b[7:4]) * 4;
                    emit_blob(b);
                    if (l4_hlen != 0 && pos + 1 == l4_hlen) begin
                        if (l4_proto == PROTO_TCP) begin
                            emit_fill(HEADER_SLOT - l4_hlen);
                            emit_fill(BLOB_LEN - 2 * HEADER_SLOT);
                        end else begin
                            emit_fill(BLOB_LEN - HEADER_SLOT - UDP_HDR_LEN);
                        end
                        parse_state = PS_DONE;
                        byte_pos    = 0;
                        advance     = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (advance && byte_pos < 255)
            byte_pos++;

        if (eof) begin
            if (parse_state == PS_ERR)
                end_code = frame_code;
            else if (parse_state == PS_DONE)
                end_code = ST_OK;
            else
                end_code = ST_MALFORMED;
            burst_q.push_back('{data: 8'h00, index: 7'd0, is_stat: 1'b1, code: end_code,
                                eop: 1'b0});
            clear_frame();
        end

        if (burst_q.size() != 0)
            burst_q[burst_q.size() - 1].eop = 1'b1;
        foreach (burst_q[i])
            blob_q.push_back(burst_q[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_value = '0;
            clear_frame();
            blob_q.delete();
            mismatches = 0;
            fail_count    <= 0;
            pending_count <= 0;
        end else begin
            if (cfg_we)
                fill_value = cfg_wdata;

            if (out_valid && out_ready) begin
                got = '{data: out_byte, index: blob_index, is_stat: is_status, code: status,
                        eop: last};
                if (blob_q.size() == 0) begin
                    mismatches++;
                    $display({"%0t: unexpected transaction: byte %02h index %0d",
                              " status flag %0b code %0d last %0b"},
                             $time, got.data, got.index, got.is_stat, got.code, got.eop);
                end else begin
                    want = blob_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        $display({"%0t: expected byte %02h index %0d",
                                  " status flag %0b code %0d last %0b"},
                                 $time, want.data, want.index, want.is_stat, want.code,
                                 want.eop);
                        $display({"%0t: actual   byte %02h index %0d",
                                  " status flag %0b code %0d last %0b"},
                                 $time, got.data, got.index, got.is_stat, got.code,
                                 got.eop);
                    end
                end
            end

            if (in_valid && in_ready)
                predict_frame_byte(in_byte, frame_last);

            fail_count    <= mismatches;
            pending_count <= blob_q.size();
        end
    end

endmodule

FILE: test/l3_l4_header_normalizer_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Header normalizer core testbench
// Feeds Ethernet frames byte by byte (well-formed TCP and UDP frames, tagged
// frames, every error kind and truncated frames) under three idle profiles
// and a long output hold-off, with the fill byte changed between phases.
// ---------------------------------------------------------------------------
module l3_l4_header_normalizer_core_tb;
    import hn_pkg::*;

    localparam int HEADER_SLOT  = 60;
    localparam int PHASE_BYTES  = 100;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int SETTLE_TICKS = 8;
    localparam int DRAIN_TICKS  = 20;

    typedef enum int {
        FK_TCP,
        FK_UDP,
        FK_NOT_IPV4,
        FK_DOUBLE_VLAN,
        FK_BAD_PROTO,
        FK_SHORT_IHL,
        FK_SHORT_TCP,
        FK_COUNT
    } frame_kind_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte    = 8'h00;
    logic       frame_last = 1'b0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [7:0] out_byte;
    logic [6:0] blob_index;
    logic       is_status;
    logic [1:0] status;
    logic       last;
    logic       cfg_we     = 1'b0;
    logic [7:0] cfg_wdata  = 8'h00;

    int         fail_count;
    int         pending_count;
    int         send_idle   = 11;
    int         recv_idle   = 77;
    logic       hold_req    = 1'b0;
    logic       hold_done   = 1'b0;
    int         hold_left   = 0;
    int         idle_cycles = 0;
    int         next_forced = 0;
    logic [7:0] frame_q[$];

    always #2 clk = ~clk;

    l3_l4_header_normalizer_core #(
        .HEADER_SLOT(HEADER_SLOT)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .frame_last(frame_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .blob_index(blob_index),
        .is_status (is_status),
        .status    (status),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    l3_l4_header_normalizer_core_checker #(
        .HEADER_SLOT(HEADER_SLOT)
    ) blob_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .frame_last   (frame_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .blob_index   (blob_index),
        .is_status    (is_status),
        .status       (status),
        .last         (last),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    always @(posedge clk)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            out_ready <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("l3_l4_header_normalizer_core: mismatch");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic eof);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_byte    <= b;
        frame_last <= eof;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    task automatic push_random(input int count);
        repeat (count) frame_q.push_back(8'($urandom));
    endtask

    task automatic write_fill(input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    function automatic frame_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return FK_TCP;
        else if (r < 65)
            return FK_UDP;
        else if (r < 73)
            return FK_NOT_IPV4;
        else if (r < 79)
            return FK_DOUBLE_VLAN;
        else if (r < 86)
            return FK_BAD_PROTO;
        else if (r < 93)
            return FK_SHORT_IHL;
        else
            return FK_SHORT_TCP;
    endfunction

    task automatic build_frame(input frame_kind_t kind, input bit may_cut);
        int          ihl_words;
        int          tcp_words;
        int          cut;
        bit          stop;
        logic [15:0] etype;
        logic [7:0]  proto;

        frame_q.delete();
        push_random(ETH_TYPE_POS);
        if (kind == FK_DOUBLE_VLAN || $urandom_range(99) < 30) begin
            frame_q.push_back(VLAN_TPID[15:8]);
            frame_q.push_back(VLAN_TPID[7:0]);
            push_random(VLAN_TYPE_POS);
        end
        if (kind == FK_DOUBLE_VLAN) begin
            etype = VLAN_TPID;
        end else if (kind == FK_NOT_IPV4) begin
            if ($urandom_range(1))
                etype = L3_TYPE_IPV4 ^ (16'h0001 << $urandom_range(15));
            else
                do
                    etype = 16'($urandom);
                while (etype == L3_TYPE_IPV4 || etype == VLAN_TPID);
        end else begin
            etype = L3_TYPE_IPV4;
        end
        frame_q.push_back(etype[15:8]);
        frame_q.push_back(etype[7:0]);
        stop = (kind == FK_DOUBLE_VLAN || kind == FK_NOT_IPV4);

        if (!stop) begin
            if (kind == FK_SHORT_IHL)
                ihl_words = $urandom_range(int'(MIN_HDR_WORDS) - 1, 0);
            else if ($urandom_range(99) < 75)
                ihl_words = MIN_HDR_WORDS;
            else
                ihl_words = $urandom_range(15, int'(MIN_HDR_WORDS));
            frame_q.push_back({4'($urandom), 4'(ihl_words)});
            stop = (kind == FK_SHORT_IHL);
        end

        if (!stop) begin
            push_random(IP_PROTO_POS - 1);
            if (kind == FK_UDP)
                proto = PROTO_UDP;
            else if (kind == FK_BAD_PROTO)
                do
                    proto = 8'($urandom);
                while (proto == PROTO_TCP || proto == PROTO_UDP);
            else
                proto = PROTO_TCP;
            frame_q.push_back(proto);
            stop = (kind == FK_BAD_PROTO);
        end

        if (!stop) begin
            push_random(ihl_words * 4 - IP_PROTO_POS - 1);
            if (kind == FK_UDP) begin
                push_random(UDP_HDR_LEN);
            end else begin
                push_random(TCP_OFFS_POS);
                if (kind == FK_SHORT_TCP)
                    tcp_words = $urandom_range(int'(MIN_HDR_WORDS) - 1, 0);
                else if ($urandom_range(99) < 75)
                    tcp_words = MIN_HDR_WORDS;
                else
                    tcp_words = $urandom_range(15, int'(MIN_HDR_WORDS));
                frame_q.push_back({4'(tcp_words), 4'($urandom)});
                if (kind != FK_SHORT_TCP)
                    push_random(tcp_words * 4 - TCP_OFFS_POS - 1);
            end
        end

        push_random($urandom_range(4));
        if (may_cut && $urandom_range(99) < 20) begin
            cut = $urandom_range(frame_q.size() - 1, 1);
            while (frame_q.size() > cut)
                void'(frame_q.pop_back());
        end
    endtask

    task automatic run_frames(input int budget, input bit with_hold);
        int sent;
        sent = 0;
        while (sent < budget) begin
            if (next_forced < FK_COUNT) begin
                build_frame(frame_kind_t'(next_forced), 1'b0);
                next_forced++;
            end else begin
                build_frame(pick_kind(), 1'b1);
            end
            if (with_hold)
                hold_req <= 1'b1;
            send_frame();
            sent += frame_q.size();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_fill(8'hFF);
        frame_q = '{8'h00};
        send_frame();
        frame_q.delete();
        repeat (ETH_TYPE_POS) frame_q.push_back(8'hFF);
        frame_q.push_back(L3_TYPE_IPV4[15:8]);
        frame_q.push_back(L3_TYPE_IPV4[7:0]);
        frame_q.push_back(8'hF4);
        send_frame();
        settle();

        write_fill(8'($urandom_range(254, 1)));
        run_frames(PHASE_BYTES, 1'b1);
        settle();

        write_fill(8'h00);
        send_idle = 77;
        recv_idle <= 11;
        run_frames(PHASE_BYTES, 1'b0);
        settle();

        write_fill(8'($urandom));
        send_idle = 0;
        recv_idle <= 0;
        run_frames(PHASE_BYTES, 1'b0);
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending_count != 0);
        repeat (DRAIN_TICKS) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("l3_l4_header_normalizer_core: match");
        else
            $display("l3_l4_header_normalizer_core: mismatch");
        $finish;
    end

endmodule
